// File: sv/ffa_pkg.sv
// Shared types, codes and control/status bundles of the feature frame accumulator.
package ffa_pkg;

  localparam int SUM_W = 48;

  typedef enum logic [1:0] {
    CMD_ELEM    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_RD_SUM  = 2'd2,
    CMD_RD_MEAN = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_CONCAT = 2'd0,
    MODE_SUM    = 2'd1,
    MODE_MEAN   = 2'd2,
    MODE_SMA    = 2'd3
  } mode_t;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [1:0] REG_FEAT_LEN  = 2'd2;
  localparam logic [1:0] REG_SPEW      = 2'd3;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_ACC   = 2'd1,
    SRC_DIV   = 2'd2,
    SRC_STORE = 2'd3
  } src_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RSUPD,
    S_SWR,
    S_CRD,
    S_CEMIT,
    S_ARD,
    S_AACC,
    S_DSTART,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic sweep_step;
    logic clr_item;
    logic store_wr;
    logic store_rd;
    logic rsum_rd;
    logic rsum_wr;
    logic acc_clr;
    logic acc_ld;
    logic acc_add;
    logic r_clr;
    logic r_inc;
    logic div_start;
    logic emit;
    src_t src;
    logic fin;
  } ctrl_t;

  typedef struct packed {
    cmd_t  cmd;
    mode_t mode;
    logic  spew;
    logic  idx_err;
    logic  concat_emit;
    logic  r_last;
    logic  div_done;
    logic  emit_ok;
    logic  sweep_last;
    logic  cfg_clr;
  } stat_t;

endpackage

// File: sv/feature_frame_accumulator_top.sv
// Top level of the feature frame accumulator: controller, datapath and ports.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    cmd, element_index, sample_value
//   out_     output     out_valid / out_ready  result_value, list_position, last/error
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// One transaction at a time, acceptance to next acceptance. Concat with output reads and
// emits each row of the store in turn; sma reads and adds every row, then divides; mean
// with spew and mean queries pass through the serial divider.
// After reset, a clear command, or a write to mode, the row count or feature_length, a sweep
// of MAX_FRAMES*MAX_LENGTH words zeros the store and sum row; in_ready stays low.
// A stalled out_ready holds the result register and any further result waits behind it.
module feature_frame_accumulator_top #(
  parameter int MAX_FRAMES = 16,
  parameter int MAX_LENGTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_element_index,
  input  logic signed [31:0] in_sample_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [9:0]         out_list_position,
  output logic               out_last_result,
  output logic               out_index_error,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata
);
  import ffa_pkg::*;

  ctrl_t ctl;
  stat_t st;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  ffa_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_element_index  (in_element_index),
    .in_sample_value   (in_sample_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .ctl               (ctl),
    .st                (st),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_list_position (out_list_position),
    .out_last_result   (out_last_result),
    .out_index_error   (out_index_error)
  );

endmodule

// File: sv/ffa_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module ffa_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [ffa_pkg::SUM_W-1:0] dividend,
  input  logic        [31:0]             divisor,
  output logic                           done,
  output logic signed [ffa_pkg::SUM_W:0]   quotient
);
  import ffa_pkg::*;

  localparam int CNW = $clog2(SUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNW-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      d_r, d_nxt;
  logic             neg_r, neg_nxt;
  logic [32:0]      rem_sh;
  logic             ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r, q_r[SUM_W-1]};
    ge       = rem_sh >= {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNW'(SUM_W - 1);
      q_nxt    = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      neg_nxt  = dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(rem_sh - {1'b0, d_r}) : rem_sh[31:0];
      q_nxt   = {q_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// File: sv/ffa_dp.sv
// Datapath: registers, frame store, sum row, divider and result register.
module ffa_dp #(
  parameter int MAX_FRAMES = 16,
  parameter int MAX_LENGTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_cmd,
  input  logic [5:0]          in_element_index,
  input  logic signed [31:0]  in_sample_value,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_wdata,
  input  ffa_pkg::ctrl_t      ctl,
  output ffa_pkg::stat_t      st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_result_value,
  output logic [9:0]          out_list_position,
  output logic                out_last_result,
  output logic                out_index_error
);
  import ffa_pkg::*;

  localparam int SD  = MAX_FRAMES * MAX_LENGTH;
  localparam int AW  = SD > 1 ? $clog2(SD) : 1;
  localparam int CW  = MAX_LENGTH > 1 ? $clog2(MAX_LENGTH) : 1;
  localparam int RIW = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
  localparam int NFW = $clog2(MAX_FRAMES + 1);
  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int PW  = NFW + LW + 1;

  function automatic logic [31:0] sat32(input logic signed [SUM_W:0] x);
    if (!x[SUM_W] && (|x[SUM_W-1:31])) return 32'h7FFF_FFFF;
    if (x[SUM_W] && !(&x[SUM_W-1:31])) return 32'h8000_0000;
    return x[31:0];
  endfunction

  mode_t               mode_r;
  logic [4:0]          row_count_r;
  logic [6:0]          feature_length_r;
  logic                spew_r;
  cmd_t                cmd_r;
  logic [5:0]          j_r;
  logic signed [31:0]  v_r;
  logic [RIW-1:0]      write_row_r;
  logic [31:0]         frames_seen_r;
  logic [AW-1:0]       sweep_r;
  logic [RIW-1:0]      r_cnt_r;
  logic signed [SUM_W-1:0] acc_r;

  logic [31:0]         store_mem [SD];
  logic [31:0]         store_rd_r;
  logic [SUM_W-1:0]    rsum_mem [MAX_LENGTH];
  logic [SUM_W-1:0]    rsum_rd_r;

  logic                out_valid_r;
  logic [31:0]         out_value_r;
  logic [9:0]          out_pos_r;
  logic                out_last_r;
  logic                out_err_r;

  logic [NFW-1:0]      nf;
  logic [LW-1:0]       fl;
  logic                cfg_clr;
  logic                idx_err;
  logic                frame_end;
  logic [NFW:0]        next_row;
  logic [NFW:0]        slot_raw;
  logic [NFW:0]        slot;
  logic [PW-1:0]       prod;
  logic [9:0]          pos_cat;
  logic [31:0]         cnt;
  logic [31:0]         div_d;
  logic                div_zero;
  logic                div_done;
  logic signed [SUM_W:0] quot;
  logic signed [SUM_W:0] sum_ext;
  logic [SUM_W-1:0]    sum_sat;
  logic                r_last;
  logic                emit_ok;
  logic                load;
  logic                store_we;
  logic [AW-1:0]       store_waddr;
  logic [AW-1:0]       store_raddr;
  logic [31:0]         store_wdata;
  logic                rsum_we;
  logic [CW-1:0]       rsum_waddr;
  logic [SUM_W-1:0]    rsum_wdata;
  logic [31:0]         emit_value;
  logic [9:0]          emit_pos;
  logic                emit_last;

  always_comb begin
    if (row_count_r == '0) nf = NFW'(1);
    else if (int'(row_count_r) > MAX_FRAMES) nf = NFW'(MAX_FRAMES);
    else nf = NFW'(row_count_r);
    if (feature_length_r == '0) fl = LW'(1);
    else if (int'(feature_length_r) > MAX_LENGTH) fl = LW'(MAX_LENGTH);
    else fl = LW'(feature_length_r);
  end

  assign cfg_clr   = cfg_we && (cfg_index == REG_MODE || cfg_index == REG_ROW_COUNT ||
                                cfg_index == REG_FEAT_LEN);
  assign idx_err   = 11'(j_r) >= 11'(fl);
  assign frame_end = 11'(j_r) == (11'(fl) - 11'd1);
  assign next_row  = (NFW+1)'(write_row_r) + (NFW+1)'(1);
  assign r_last    = NFW'(r_cnt_r) == (nf - NFW'(1));
  assign cnt       = (frames_seen_r == 32'hFFFF_FFFF) ? frames_seen_r : frames_seen_r + 32'd1;

  always_comb begin
    slot_raw = (NFW+1)'(nf) - next_row + (NFW+1)'(r_cnt_r);
    slot     = (slot_raw >= (NFW+1)'(nf)) ? slot_raw - (NFW+1)'(nf) : slot_raw;
    prod     = PW'(slot) * PW'(fl);
    pos_cat  = 10'(prod + PW'(j_r));
  end

  always_comb begin
    if (cmd_r == CMD_RD_MEAN) div_d = frames_seen_r;
    else if (mode_r == MODE_SMA) div_d = 32'(nf);
    else div_d = cnt;
    div_zero = div_d == '0;
  end

  assign sum_ext = $signed({rsum_rd_r[SUM_W-1], rsum_rd_r}) +
                   $signed({{(SUM_W-31){v_r[31]}}, v_r});
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sum_sat = sum_ext[SUM_W-1:0];
  end

  ffa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (acc_r),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    store_we    = ctl.sweep_step || ctl.store_wr;
    store_waddr = ctl.sweep_step ? sweep_r
                                 : AW'(int'(write_row_r) * MAX_LENGTH + int'(j_r));
    store_wdata = ctl.sweep_step ? '0 : v_r;
    store_raddr = AW'(int'(r_cnt_r) * MAX_LENGTH + int'(j_r));
    rsum_we     = (ctl.sweep_step && (int'(sweep_r) < MAX_LENGTH)) || ctl.rsum_wr;
    rsum_waddr  = ctl.sweep_step ? CW'(sweep_r) : CW'(j_r);
    rsum_wdata  = ctl.sweep_step ? '0 : sum_sat;
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= store_wdata;
    if (ctl.store_rd) store_rd_r <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (rsum_we) rsum_mem[rsum_waddr] <= rsum_wdata;
    if (ctl.rsum_rd) rsum_rd_r <= rsum_mem[CW'(j_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_CONCAT;
      row_count_r      <= 5'd5;
      feature_length_r <= 7'd50;
      spew_r           <= 1'b0;
      write_row_r      <= '0;
      frames_seen_r    <= '0;
      sweep_r          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:      mode_r           <= mode_t'(cfg_wdata[1:0]);
          REG_ROW_COUNT: row_count_r      <= cfg_wdata[4:0];
          REG_FEAT_LEN:  feature_length_r <= cfg_wdata;
          REG_SPEW:      spew_r           <= cfg_wdata[0];
          default:       spew_r           <= spew_r;
        endcase
      end
      if (cfg_clr || ctl.clr_item) sweep_r <= '0;
      else if (ctl.sweep_step) sweep_r <= sweep_r + AW'(1);
      if (cfg_clr || ctl.clr_item) begin
        write_row_r <= '0;
      end else if (ctl.fin && frame_end &&
                   (mode_r == MODE_CONCAT || mode_r == MODE_SMA)) begin
        write_row_r <= (next_row >= (NFW+1)'(nf)) ? '0 : RIW'(next_row);
      end
      if ((cfg_we && cfg_index == REG_MODE) || ctl.clr_item) frames_seen_r <= '0;
      else if (ctl.fin && frame_end) frames_seen_r <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= cmd_t'(in_cmd);
      j_r   <= in_element_index;
      v_r   <= in_sample_value;
    end
    if (ctl.r_clr) r_cnt_r <= '0;
    else if (ctl.r_inc) r_cnt_r <= r_cnt_r + RIW'(1);
    if (ctl.acc_clr) acc_r <= '0;
    else if (ctl.acc_ld) acc_r <= (cmd_r == CMD_ELEM) ? sum_sat : rsum_rd_r;
    else if (ctl.acc_add) acc_r <= acc_r + {{(SUM_W-32){store_rd_r[31]}}, store_rd_r};
  end

  always_comb begin
    emit_pos  = 10'(j_r);
    emit_last = 1'b1;
    case (ctl.src)
      SRC_ZERO: begin
        emit_value = '0;
        emit_pos   = '0;
      end
      SRC_ACC:  emit_value = sat32({acc_r[SUM_W-1], acc_r});
      SRC_DIV:  emit_value = div_zero ? '0 : sat32(quot);
      SRC_STORE: begin
        emit_value = store_rd_r;
        emit_pos   = pos_cat;
        emit_last  = r_last;
      end
      default:  emit_value = '0;
    endcase
  end

  assign emit_ok = !out_valid_r || out_ready;
  assign load    = ctl.emit && emit_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
    if (load) begin
      out_value_r <= emit_value;
      out_pos_r   <= emit_pos;
      out_last_r  <= emit_last;
      out_err_r   <= ctl.src == SRC_ZERO;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_list_position = out_pos_r;
  assign out_last_result   = out_last_r;
  assign out_index_error   = out_err_r;

  always_comb begin
    st.cmd         = cmd_r;
    st.mode        = mode_r;
    st.spew        = spew_r;
    st.idx_err     = idx_err;
    st.concat_emit = (next_row == (NFW+1)'(nf)) || spew_r;
    st.r_last      = r_last;
    st.div_done    = div_done;
    st.emit_ok     = emit_ok;
    st.sweep_last  = sweep_r == AW'(SD - 1);
    st.cfg_clr     = cfg_clr;
  end

endmodule

// File: sv/ffa_ctrl.sv
// Controller state machine sequencing each transaction through the datapath.
module ffa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffa_pkg::stat_t  st,
  output ffa_pkg::ctrl_t  ctl
);
  import ffa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    ctl       = '0;
    ctl.src   = SRC_ZERO;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        ctl.sweep_step = 1'b1;
        if (st.sweep_last && !st.cfg_clr) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !st.cfg_clr;
        if (st.cfg_clr) begin
          state_nxt = S_CLEAR;
        end else if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.cmd == CMD_CLEAR) begin
          ctl.clr_item = 1'b1;
          state_nxt    = S_CLEAR;
        end else if (st.idx_err) begin
          state_nxt = S_EMIT;
        end else if (st.cmd != CMD_ELEM ||
                     st.mode == MODE_SUM || st.mode == MODE_MEAN) begin
          ctl.rsum_rd = 1'b1;
          state_nxt   = S_RSUPD;
        end else begin
          state_nxt = S_SWR;
        end
      end
      S_RSUPD: begin
        ctl.acc_ld  = 1'b1;
        ctl.rsum_wr = st.cmd == CMD_ELEM;
        if (st.cmd == CMD_RD_SUM) state_nxt = S_EMIT;
        else if (st.cmd == CMD_RD_MEAN) state_nxt = S_DSTART;
        else if (!st.spew) begin
          ctl.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else if (st.mode == MODE_SUM) state_nxt = S_EMIT;
        else state_nxt = S_DSTART;
      end
      S_SWR: begin
        ctl.store_wr = 1'b1;
        ctl.acc_clr  = 1'b1;
        ctl.r_clr    = 1'b1;
        if (st.mode == MODE_SMA) state_nxt = S_ARD;
        else if (st.concat_emit) state_nxt = S_CRD;
        else begin
          ctl.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CRD: begin
        ctl.store_rd = 1'b1;
        state_nxt    = S_CEMIT;
      end
      S_CEMIT: begin
        ctl.emit = 1'b1;
        ctl.src  = SRC_STORE;
        if (st.emit_ok) begin
          if (st.r_last) begin
            ctl.fin   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ctl.r_inc = 1'b1;
            state_nxt = S_CRD;
          end
        end
      end
      S_ARD: begin
        ctl.store_rd = 1'b1;
        state_nxt    = S_AACC;
      end
      S_AACC: begin
        ctl.acc_add = 1'b1;
        if (st.r_last) state_nxt = S_DSTART;
        else begin
          ctl.r_inc = 1'b1;
          state_nxt = S_ARD;
        end
      end
      S_DSTART: begin
        ctl.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit = 1'b1;
        if (st.idx_err) ctl.src = SRC_ZERO;
        else if (st.cmd == CMD_RD_MEAN ||
                 (st.cmd == CMD_ELEM && st.mode != MODE_SUM)) ctl.src = SRC_DIV;
        else ctl.src = SRC_ACC;
        if (st.emit_ok) begin
          ctl.fin   = (st.cmd == CMD_ELEM) && !st.idx_err;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: tb/ffa_checker.sv
// Checker: watches the channels, predicts each transaction's results and compares them.
module ffa_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_element_index,
  input  logic signed [31:0] in_sample_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_result_value,
  input  logic [9:0]         out_list_position,
  input  logic               out_last_result,
  input  logic               out_index_error,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata,
  output int                 fail_count,
  output int                 pending_count
);
  import ffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value;
    logic [9:0]         pos;
    logic               last;
    logic               err;
  } accum_result_t;

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  accum_result_t      expected_results[$];
  logic signed [31:0] frame_rows[16][64];
  longint             column_sums[64];
  logic [4:0]         row_ptr;
  logic [31:0]        frame_count;
  mode_t              acc_mode;
  logic [4:0]         frames_reg;
  logic [6:0]         length_reg;
  logic               spew_reg;

  assign pending_count = expected_results.size();

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic void clear_store();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 64; c++) frame_rows[r][c] = '0;
    for (int c = 0; c < 64; c++) column_sums[c] = 0;
    row_ptr = '0;
  endfunction

  function automatic void expect_result(logic signed [31:0] v, int p, logic l, logic e);
    accum_result_t x;
    x.value = v;
    x.pos   = p[9:0];
    x.last  = l;
    x.err   = e;
    expected_results.push_back(x);
  endfunction

  function automatic void predict_accumulation(logic [1:0] c, logic [5:0] j,
                                               logic signed [31:0] v);
    int nf, fl, row, nxt;
    longint s;
    logic [31:0] cnt;
    nf  = frames_reg == 0 ? 1 : (frames_reg > 16 ? 16 : int'(frames_reg));
    fl  = length_reg == 0 ? 1 : (length_reg > 64 ? 64 : int'(length_reg));
    row = row_ptr < nf ? int'(row_ptr) : 0;
    if (c == CMD_CLEAR) begin
      clear_store();
      frame_count = '0;
      return;
    end
    if (j >= fl) begin
      expect_result('0, 0, 1'b1, 1'b1);
      return;
    end
    if (c == CMD_RD_SUM) begin
      expect_result(clamp32(column_sums[j]), j, 1'b1, 1'b0);
      return;
    end
    if (c == CMD_RD_MEAN) begin
      expect_result(frame_count != 0 ? clamp32(column_sums[j] / longint'(frame_count)) : '0,
                    j, 1'b1, 1'b0);
      return;
    end
    nxt = row + 1;
    cnt = (frame_count == 32'hFFFF_FFFF) ? frame_count : frame_count + 1;
    if (acc_mode == MODE_CONCAT || acc_mode == MODE_SMA) begin
      frame_rows[row][j] = v;
    end else begin
      s = column_sums[j] + longint'(v);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      column_sums[j] = s;
    end
    case (acc_mode)
      MODE_CONCAT: begin
        if (nxt == nf || spew_reg)
          for (int r = 0; r < nf; r++)
            expect_result(frame_rows[r][j], ((nf - nxt + r) % nf) * fl + j, r == nf - 1, 1'b0);
      end
      MODE_SUM: begin
        if (spew_reg) expect_result(clamp32(column_sums[j]), j, 1'b1, 1'b0);
      end
      MODE_MEAN: begin
        if (spew_reg)
          expect_result(clamp32(column_sums[j] / longint'(cnt)), j, 1'b1, 1'b0);
      end
      default: begin
        s = 0;
        for (int r = 0; r < nf; r++) s += longint'(frame_rows[r][j]);
        expect_result(clamp32(s / longint'(nf)), j, 1'b1, 1'b0);
      end
    endcase
    if (j == fl - 1) begin
      frame_count = cnt;
      if (acc_mode == MODE_CONCAT || acc_mode == MODE_SMA)
        row_ptr = nxt >= nf ? 5'd0 : 5'(nxt);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    accum_result_t e;
    if (!rst_n) begin
      expected_results.delete();
      clear_store();
      frame_count = '0;
      acc_mode    = MODE_CONCAT;
      frames_reg  = 5'd5;
      length_reg  = 7'd50;
      spew_reg    = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: begin
            acc_mode = mode_t'(cfg_wdata[1:0]);
            clear_store();
            frame_count = '0;
          end
          REG_ROW_COUNT: begin
            frames_reg = cfg_wdata[4:0];
            clear_store();
          end
          REG_FEAT_LEN: begin
            length_reg = cfg_wdata;
            clear_store();
          end
          default: spew_reg = cfg_wdata[0];
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, value", out_result_value, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_result_value !== e.value)
            report_mismatch("result_value", out_result_value, e.value);
          if (out_list_position !== e.pos)
            report_mismatch("list_position", out_list_position, e.pos);
          if (out_last_result !== e.last)
            report_mismatch("last_result", out_last_result, e.last);
          if (out_index_error !== e.err)
            report_mismatch("index_error", out_index_error, e.err);
        end
      end
      if (in_valid && in_ready)
        predict_accumulation(in_cmd, in_element_index, in_sample_value);
    end
  end

endmodule

// File: tb/tb_feature_frame_accumulator_top.sv
// Testbench top: clock, reset, stimulus, receiver back-pressure and verdict.
module tb_feature_frame_accumulator_top;
  import ffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = CMD_ELEM;
  logic [5:0]         in_element_index = '0;
  logic signed [31:0] in_sample_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_result_value;
  logic [9:0]         out_list_position;
  logic               out_last_result;
  logic               out_index_error;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_MODE;
  logic [6:0]         cfg_wdata = '0;

  int  fail_count, pending_count;
  int  accepted_count = 0;
  int  cycle_count = 0;
  int  hold_off = 0;
  int  sink_gap = 0;
  bit  quiet = 1'b0;
  int  length_now = 50;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  feature_frame_accumulator_top u_dut (.*);

  ffa_checker u_checker (.*);

  always @(posedge clk) begin
    if (in_valid && in_ready) accepted_count <= accepted_count + 1;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_feature_frame_accumulator_top NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready = 1'b0;
      hold_off--;
    end else if (sink_gap > 0) begin
      out_ready = 1'b0;
      sink_gap--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      sink_gap = $urandom_range(1, 14) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic send_transaction(cmd_t c, logic [5:0] j, logic signed [31:0] v);
    int before_count;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = c;
    in_element_index = j;
    in_sample_value = v;
    before_count = accepted_count;
    do @(negedge clk); while (accepted_count == before_count);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    drain_results();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_FEAT_LEN) length_now = val == 0 ? 1 : (val > 64 ? 64 : int'(val));
  endtask

  task automatic configure(mode_t m, logic [4:0] nf, logic [6:0] fl, logic sp);
    write_reg(REG_MODE, 7'(m));
    write_reg(REG_ROW_COUNT, 7'(nf));
    write_reg(REG_FEAT_LEN, fl);
    write_reg(REG_SPEW, 7'(sp));
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int count);
    int j;
    cmd_t c;
    j = 0;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0: send_transaction(CMD_CLEAR, 6'($urandom), $urandom);
        1, 2: begin
          c = $urandom_range(0, 1) ? CMD_RD_SUM : CMD_RD_MEAN;
          send_transaction(c, 6'($urandom_range(0, length_now - 1)), $urandom);
        end
        3: send_transaction(CMD_ELEM, 6'($urandom), pick_value());
        default: begin
          send_transaction(CMD_ELEM, 6'(j), pick_value());
          j = (j + 1) % length_now;
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    configure(MODE_CONCAT, 5'd2, 7'd3, 1'b0);
    send_transaction(CMD_ELEM, 6'd0, 32'sh7FFF_FFFF);
    send_transaction(CMD_ELEM, 6'd1, 32'sh8000_0000);
    send_transaction(CMD_ELEM, 6'd2, 32'sd0);
    send_transaction(CMD_ELEM, 6'd0, 32'sh0001_0000);
    send_transaction(CMD_ELEM, 6'd1, -32'sd1);
    send_transaction(CMD_ELEM, 6'd2, 32'sh5555_AAAA);
    send_transaction(CMD_ELEM, 6'd5, 32'sd7);
    send_transaction(CMD_RD_SUM, 6'd63, 32'sd0);
    send_transaction(CMD_CLEAR, 6'd0, 32'sd0);
    send_transaction(CMD_RD_MEAN, 6'd0, 32'sd0);
    send_transaction(CMD_RD_SUM, 6'd2, 32'sd0);
    configure(MODE_SUM, 5'd16, 7'd1, 1'b1);
    send_transaction(CMD_ELEM, 6'd0, 32'sh7FFF_FFFF);
    send_transaction(CMD_ELEM, 6'd0, 32'sh7FFF_FFFF);
    send_transaction(CMD_RD_MEAN, 6'd0, 32'sd0);
    configure(MODE_MEAN, 5'd1, 7'd2, 1'b1);
    send_transaction(CMD_ELEM, 6'd0, -32'sd7);
    send_transaction(CMD_ELEM, 6'd1, 32'sh8000_0000);
    send_transaction(CMD_ELEM, 6'd0, 32'sd2);
    send_transaction(CMD_RD_MEAN, 6'd0, 32'sd0);
    configure(MODE_SMA, 5'd3, 7'd1, 1'b0);
    send_transaction(CMD_ELEM, 6'd0, -32'sd5);
    send_transaction(CMD_ELEM, 6'd0, 32'sh7FFF_FFFF);
    send_transaction(CMD_ELEM, 6'd0, 32'sh7FFF_FFFF);

    configure(MODE_CONCAT, 5'd0, 7'd0, 1'b1);
    random_phase(12);
    configure(MODE_CONCAT, 5'd31, 7'd127, 1'b1);
    hold_off = 400;
    random_phase(20);
    configure(MODE_CONCAT, 5'd4, 7'd3, 1'b0);
    random_phase(25);
    drain_results();
    random_phase(10);
    configure(MODE_SUM, 5'd7, 7'd4, 1'b1);
    random_phase(25);
    configure(MODE_MEAN, 5'd16, 7'd64, 1'b1);
    random_phase(15);
    configure(MODE_MEAN, 5'd2, 7'd3, 1'b0);
    random_phase(20);
    configure(MODE_SMA, 5'd16, 7'd2, 1'b0);
    random_phase(25);
    configure(MODE_SMA, 5'(($urandom_range(1, 5))), 7'($urandom_range(1, 6)), 1'b1);
    random_phase(20);
    configure(MODE_CONCAT, 5'd3, 7'd2, 1'b1);
    quiet = 1'b1;
    random_phase(25);

    drain_results();
    if (fail_count == 0) begin
      $display("tb_feature_frame_accumulator_top OK");
    end else begin
      $display("tb_feature_frame_accumulator_top NOT OK");
    end
    $finish;
  end

endmodule
